[sv/ufe_pkg.sv]
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared types, constants and the control store of the union-find engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

   localparam int NODES   = 1024;
   localparam int IDX_W   = $clog2(NODES);
   localparam int SIZE_W  = IDX_W + 1;
   localparam int ENTRY_W = SIZE_W + 1;
   localparam int STEP_W  = 4;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * IDX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IDX_W + 7) / 8) * 8;

   // entry: [ENTRY_W-1] root flag, [SIZE_W-1:0] set size (root) or parent index
   localparam int ROOT_BIT = ENTRY_W - 1;

   localparam logic KIND_FIND  = 1'b0;
   localparam logic KIND_MERGE = 1'b1;

   // control store addresses
   localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] S_FETCH    = 4'd1;
   localparam logic [STEP_W-1:0] S_WALK     = 4'd2;
   localparam logic [STEP_W-1:0] S_HALVE    = 4'd3;
   localparam logic [STEP_W-1:0] S_RET      = 4'd4;
   localparam logic [STEP_W-1:0] S_NEXT     = 4'd5;
   localparam logic [STEP_W-1:0] S_ORDER    = 4'd6;
   localparam logic [STEP_W-1:0] S_WR_ROOT  = 4'd7;
   localparam logic [STEP_W-1:0] S_WR_CHILD = 4'd8;
   localparam logic [STEP_W-1:0] S_OUT      = 4'd9;
   localparam logic [STEP_W-1:0] S_CLR      = 4'd10;

   typedef enum logic {
      RD_CUR  = 1'b0,
      RD_LINK = 1'b1
   } rd_sel_type;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_STEP1    = 4'd2,
      OP_STEP2    = 4'd3,
      OP_LOAD_B   = 4'd4,
      OP_ORDER    = 4'd5,
      OP_WR_ROOT  = 4'd6,
      OP_WR_CHILD = 4'd7,
      OP_EMIT     = 4'd8,
      OP_CLEAR    = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_REQ      = 3'd1,
      COND_ROOT     = 3'd2,
      COND_PHASE1   = 3'd3,
      COND_IS_FIND  = 3'd4,
      COND_SAME     = 3'd5,
      COND_RSP_BUSY = 3'd6,
      COND_CLR_LAST = 3'd7
   } cond_type;

   typedef struct packed {
      rd_sel_type        rd_sel;
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] jmp_t;
      logic [STEP_W-1:0] jmp_f;
   } uword_type;

   typedef struct packed {
      logic root;
      logic phase;
      logic is_find;
      logic same;
      logic clr_last;
   } dp_status_type;

   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{RD_CUR, OP_NONE, COND_ALWAYS, S_IDLE, S_IDLE};
      unique case (step)
         S_IDLE:     w = '{RD_CUR,  OP_LOAD,     COND_REQ,      S_FETCH,    S_IDLE};
         S_FETCH:    w = '{RD_CUR,  OP_NONE,     COND_ALWAYS,   S_WALK,     S_WALK};
         S_WALK:     w = '{RD_LINK, OP_STEP1,    COND_ROOT,     S_RET,      S_HALVE};
         S_HALVE:    w = '{RD_LINK, OP_STEP2,    COND_ROOT,     S_RET,      S_WALK};
         S_RET:      w = '{RD_CUR,  OP_NONE,     COND_PHASE1,   S_ORDER,    S_NEXT};
         S_NEXT:     w = '{RD_CUR,  OP_LOAD_B,   COND_IS_FIND,  S_OUT,      S_FETCH};
         S_ORDER:    w = '{RD_CUR,  OP_ORDER,    COND_SAME,     S_OUT,      S_WR_ROOT};
         S_WR_ROOT:  w = '{RD_CUR,  OP_WR_ROOT,  COND_ALWAYS,   S_WR_CHILD, S_WR_CHILD};
         S_WR_CHILD: w = '{RD_CUR,  OP_WR_CHILD, COND_ALWAYS,   S_OUT,      S_OUT};
         S_OUT:      w = '{RD_CUR,  OP_EMIT,     COND_RSP_BUSY, S_OUT,      S_IDLE};
         S_CLR:      w = '{RD_CUR,  OP_CLEAR,    COND_CLR_LAST, S_IDLE,     S_CLR};
         default:    w = '{RD_CUR,  OP_NONE,     COND_ALWAYS,   S_IDLE,     S_IDLE};
      endcase
      return w;
   endfunction

endpackage

[sv/ufe_sequencer.sv]
// ----------------------------------------------------------------------------
// ufe_sequencer
// Step counter over the control store with two-way conditional jumps.
// ----------------------------------------------------------------------------
module ufe_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  ufe_pkg::dp_status_type status,
   input  logic                   req_valid,
   input  logic                   rsp_busy,
   output ufe_pkg::uword_type     ctrl
);

   logic [ufe_pkg::STEP_W-1:0] upc_ff;
   logic [ufe_pkg::STEP_W-1:0] upc_in;
   ufe_pkg::uword_type         word;
   logic                       taken;

   assign word = ufe_pkg::ucode(upc_ff);
   assign ctrl = word;

   always_comb begin
      unique case (word.cond)
         ufe_pkg::COND_ALWAYS:   taken = 1'b1;
         ufe_pkg::COND_REQ:      taken = req_valid;
         ufe_pkg::COND_ROOT:     taken = status.root;
         ufe_pkg::COND_PHASE1:   taken = status.phase;
         ufe_pkg::COND_IS_FIND:  taken = status.is_find;
         ufe_pkg::COND_SAME:     taken = status.same;
         ufe_pkg::COND_RSP_BUSY: taken = rsp_busy;
         ufe_pkg::COND_CLR_LAST: taken = status.clr_last;
         default:                taken = 1'b1;
      endcase
      upc_in = taken ? word.jmp_t : word.jmp_f;
   end

   // reset starts in the table clearing loop
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ufe_pkg::S_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[sv/ufe_datapath.sv]
// ----------------------------------------------------------------------------
// ufe_datapath
// Parent table memory, walk registers and root/size bookkeeping.
// ----------------------------------------------------------------------------
module ufe_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ufe_pkg::uword_type            ctrl,
   input  logic                          req_fire,
   input  logic                          req_kind,
   input  logic [ufe_pkg::IDX_W-1:0]     req_node_a,
   input  logic [ufe_pkg::IDX_W-1:0]     req_node_b,
   input  logic                          emit_fire,
   output ufe_pkg::dp_status_type        status,
   output logic [ufe_pkg::IDX_W-1:0]     res_root,
   output logic                          res_joined
);

   localparam int IW = ufe_pkg::IDX_W;
   localparam int SW = ufe_pkg::SIZE_W;
   localparam int EW = ufe_pkg::ENTRY_W;

   logic [EW-1:0] mem [ufe_pkg::NODES];
   logic [EW-1:0] rdata_ff;

   logic          phase_ff,  phase_in;
   logic          kind_ff,   kind_in;
   logic          joined_ff, joined_in;
   logic [IW-1:0] clr_ff,    clr_in;
   logic [IW-1:0] cur_ff,    cur_in;
   logic [IW-1:0] par_ff,    par_in;
   logic [IW-1:0] nb_ff,     nb_in;
   logic [IW-1:0] ra_ff,     ra_in;
   logic [IW-1:0] rb_ff,     rb_in;
   logic [SW-1:0] sa_ff,     sa_in;
   logic [SW-1:0] sb_ff,     sb_in;
   logic [IW-1:0] x_ff,      x_in;
   logic [IW-1:0] y_ff,      y_in;
   logic [SW-1:0] sum_ff,    sum_in;

   logic          rd_root;
   logic [IW-1:0] rd_link;
   logic [SW-1:0] rd_size;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          found;
   logic [IW-1:0] found_node;

   assign rd_root = rdata_ff[ufe_pkg::ROOT_BIT];
   assign rd_size = rdata_ff[SW-1:0];
   assign rd_link = rdata_ff[IW-1:0];
   assign rd_addr = (ctrl.rd_sel == ufe_pkg::RD_LINK) ? rd_link : cur_ff;

   assign status.root     = rd_root;
   assign status.phase    = phase_ff;
   assign status.is_find  = (kind_ff == ufe_pkg::KIND_FIND);
   assign status.same     = (ra_ff == rb_ff);
   assign status.clr_last = &clr_ff;

   assign res_root   = (kind_ff == ufe_pkg::KIND_MERGE) ? x_ff : ra_ff;
   assign res_joined = (kind_ff == ufe_pkg::KIND_MERGE) & joined_ff;

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      joined_in  = joined_ff;
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      par_in     = par_ff;
      nb_in      = nb_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      sum_in     = sum_ff;
      wr_en      = 1'b0;
      wr_addr    = cur_ff;
      wr_data    = {1'b0, {(SW-IW){1'b0}}, rd_link};
      found      = 1'b0;
      found_node = cur_ff;

      unique case (ctrl.op)
         ufe_pkg::OP_LOAD: begin
            if (req_fire) begin
               kind_in  = req_kind;
               cur_in   = req_node_a;
               nb_in    = req_node_b;
               phase_in = 1'b0;
            end
         end
         ufe_pkg::OP_STEP1: begin
            if (rd_root) begin
               found      = 1'b1;
               found_node = cur_ff;
            end else begin
               par_in = rd_link;
            end
         end
         ufe_pkg::OP_STEP2: begin
            if (rd_root) begin
               found      = 1'b1;
               found_node = par_ff;
            end else begin
               // path halving: point the current node at its grandparent
               wr_en  = 1'b1;
               cur_in = rd_link;
            end
         end
         ufe_pkg::OP_LOAD_B: begin
            cur_in   = nb_ff;
            phase_in = 1'b1;
         end
         ufe_pkg::OP_ORDER: begin
            joined_in = (ra_ff != rb_ff);
            sum_in    = sa_ff + sb_ff;
            // on equal sizes the first root stays on top
            if (sa_ff < sb_ff) begin
               x_in = rb_ff;
               y_in = ra_ff;
            end else begin
               x_in = ra_ff;
               y_in = rb_ff;
            end
         end
         ufe_pkg::OP_WR_ROOT: begin
            wr_en   = 1'b1;
            wr_addr = x_ff;
            wr_data = {1'b1, sum_ff};
         end
         ufe_pkg::OP_WR_CHILD: begin
            wr_en   = 1'b1;
            wr_addr = y_ff;
            wr_data = {1'b0, {(SW-IW){1'b0}}, x_ff};
         end
         ufe_pkg::OP_EMIT: begin
            if (emit_fire) begin
               joined_in = 1'b0;
            end
         end
         ufe_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b1, SW'(1)};
            clr_in  = clr_ff + 1'b1;
         end
         default: begin
         end
      endcase

      if (found) begin
         if (phase_ff) begin
            rb_in = found_node;
            sb_in = rd_size;
         end else begin
            ra_in = found_node;
            sa_in = rd_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         kind_ff   <= ufe_pkg::KIND_FIND;
         joined_ff <= 1'b0;
         clr_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         joined_ff <= joined_in;
         clr_ff    <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      par_ff <= par_in;
      nb_ff  <= nb_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      sum_ff <= sum_in;
   end

endmodule

[sv/union_find_engine_unit.sv]
// ----------------------------------------------------------------------------
// union_find_engine_unit
// Disjoint-set engine with union by size and path halving.
// ----------------------------------------------------------------------------
// One transaction at a time runs through a small control store. After a
// request is taken, a find fetches the start node's entry and walks up the
// parent chain (the table, with one read and one write port, returns the
// parent in the walk step and the grandparent in the halving step, where the
// halving write goes out), then hands the result to the output register,
// waiting while the output is stalled; a merge runs two finds back to
// back, then a compare step and, when the sets join, a root write and a child
// write. Union by size keeps every walk at or below log2(1024) = 10 levels.
// After reset the engine sweeps the table to all roots of size one and
// accepts no request until that pass is done. A finished result sits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
module union_find_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // node_a [9:0], node_b [19:10], zero [23:20]
   input  logic [ufe_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,   // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ufe_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // root [9:0], zero [15:10]
   output logic                             rsp_tuser    // joined
);

   localparam int IW = ufe_pkg::IDX_W;

   ufe_pkg::uword_type     ctrl;
   ufe_pkg::dp_status_type status;

   logic          req_fire;
   logic          rsp_busy;
   logic          emit_fire;
   logic [IW-1:0] res_root;
   logic          res_joined;

   logic          rsp_valid_ff,  rsp_valid_in;
   logic [IW-1:0] rsp_root_ff,   rsp_root_in;
   logic          rsp_joined_ff, rsp_joined_in;

   assign req_tready = (ctrl.op == ufe_pkg::OP_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_busy   = rsp_valid_ff & ~rsp_tready;
   assign emit_fire  = (ctrl.op == ufe_pkg::OP_EMIT) & ~rsp_busy;

   ufe_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_valid (req_tvalid),
      .rsp_busy  (rsp_busy),
      .ctrl      (ctrl)
   );

   ufe_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_fire   (req_fire),
      .req_kind   (req_tuser),
      .req_node_a (req_tdata[IW-1:0]),
      .req_node_b (req_tdata[2*IW-1:IW]),
      .emit_fire  (emit_fire),
      .status     (status),
      .res_root   (res_root),
      .res_joined (res_joined)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_joined_in = rsp_joined_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_root_in   = res_root;
         rsp_joined_in = res_joined;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_root_ff   <= rsp_root_in;
      rsp_joined_ff <= rsp_joined_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ufe_pkg::RSP_DATA_W'(rsp_root_ff);
   assign rsp_tuser  = rsp_joined_ff;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the union-find engine.
// ----------------------------------------------------------------------------
// A short table of find and merge requests runs first: edge indexes, self
// merges, equal-size ties and a small doubling tree deep enough to exercise
// path halving. Random traffic follows. Most of it is doubling builds and
// bursts inside narrow node windows, so that sets grow and parent chains get
// long. The rest is full-range noise. A forest model inside the bench tracks
// parents and set sizes and predicts the root and joined flag of every
// accepted request. Both channels stall in random bursts, and once the result
// side holds off long enough to back the engine up into its request side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 740;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_LEN      = 400;
   localparam int CALM_TAIL     = 80;
   localparam int DRAIN_CYCLES  = 64;

   typedef struct packed {
      logic                      kind;
      logic [ufe_pkg::IDX_W-1:0] node_a;
      logic [ufe_pkg::IDX_W-1:0] node_b;
      logic                      given;    // expected values below are typed in
      logic [ufe_pkg::IDX_W-1:0] root;
      logic                      joined;
   } stim_row_type;

   typedef struct {
      logic [ufe_pkg::IDX_W-1:0] root;
      logic                      joined;
   } answer_type;

   // root and joined flag are typed in only where they are plain to see
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ufe_pkg::KIND_FIND,  10'd0,    10'd1023, 1'b1, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd1023, 10'd0,    1'b1, 10'd1023, 1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd0,    10'd0,    1'b1, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd1023, 10'd0,    1'b1, 10'd1023, 1'b1},
      '{ufe_pkg::KIND_MERGE, 10'd0,    10'd1023, 1'b1, 10'd1023, 1'b0},
      '{ufe_pkg::KIND_FIND,  10'd0,    10'd0,    1'b1, 10'd1023, 1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd341,  10'd682,  1'b1, 10'd341,  1'b1},
      '{ufe_pkg::KIND_MERGE, 10'd682,  10'd1023, 1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd16,   10'd17,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd18,   10'd19,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd20,   10'd21,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd22,   10'd23,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd16,   10'd18,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd20,   10'd22,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd23,   10'd17,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd17,   10'd0,    1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd19,   10'd0,    1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd23,   10'd0,    1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd5,    10'd5,    1'b1, 10'd5,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd1,    10'd16,   1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd19,   10'd682,  1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd1,    10'd1023, 1'b0, 10'd0,    1'b0},
      '{ufe_pkg::KIND_FIND,  10'd512,  10'd511,  1'b1, 10'd512,  1'b0},
      '{ufe_pkg::KIND_MERGE, 10'd1022, 10'd1022, 1'b1, 10'd1022, 1'b0}
   };

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ufe_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             req_tuser  = ufe_pkg::KIND_FIND;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ufe_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tuser;

   // expectation riding along with the request on the bus
   logic                      cur_given  = 1'b0;
   logic [ufe_pkg::IDX_W-1:0] cur_root   = '0;
   logic                      cur_joined = 1'b0;

   // forest model: root flag plus set size (root) or parent index
   bit                         node_is_root [ufe_pkg::NODES];
   logic [ufe_pkg::SIZE_W-1:0] node_link    [ufe_pkg::NODES];

   stim_row_type stim_q[$];
   answer_type   root_answer_q[$];
   int           mismatches   = 0;
   int           cycle_count  = 0;
   bit           quiet        = 1'b0;
   bit           hold_request = 1'b0;
   bit           hold_done    = 1'b0;

   always #2 clock = ~clock;

   union_find_engine_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // walk to the root, pointing each visited node whose parent is not a root at its grandparent
   function automatic logic [ufe_pkg::IDX_W-1:0] climb_to_root(
      input logic [ufe_pkg::IDX_W-1:0] start);
      logic [ufe_pkg::IDX_W-1:0] x;
      logic [ufe_pkg::IDX_W-1:0] p;
      logic [ufe_pkg::IDX_W-1:0] g;
      int                        steps;
      x = start;
      steps = 0;
      while (!node_is_root[x] && steps < ufe_pkg::NODES) begin
         p = node_link[x][ufe_pkg::IDX_W-1:0];
         if (node_is_root[p]) return p;
         g = node_link[p][ufe_pkg::IDX_W-1:0];
         node_link[x] = ufe_pkg::SIZE_W'(g);
         x = g;
         steps++;
      end
      return x;
   endfunction

   function automatic answer_type resolve_item(input logic kind,
                                               input logic [ufe_pkg::IDX_W-1:0] a,
                                               input logic [ufe_pkg::IDX_W-1:0] b);
      answer_type                ans;
      logic [ufe_pkg::IDX_W-1:0] x;
      logic [ufe_pkg::IDX_W-1:0] y;
      logic [ufe_pkg::IDX_W-1:0] t;
      ans.joined = 1'b0;
      if (kind == ufe_pkg::KIND_FIND) begin
         ans.root = climb_to_root(a);
      end else begin
         x = climb_to_root(a);
         y = climb_to_root(b);
         if (x != y) begin
            // smaller set goes under the larger, ties keep the first root
            if (node_link[x] < node_link[y]) begin
               t = x;
               x = y;
               y = t;
            end
            node_link[x]    = node_link[x] + node_link[y];
            node_is_root[y] = 1'b0;
            node_link[y]    = ufe_pkg::SIZE_W'(x);
            ans.joined      = 1'b1;
         end
         ans.root = x;
      end
      return ans;
   endfunction

   function automatic void add_item(input logic kind, input int a, input int b);
      stim_row_type row;
      row        = '0;
      row.kind   = kind;
      row.node_a = ufe_pkg::IDX_W'(a);
      row.node_b = ufe_pkg::IDX_W'(b);
      stim_q.push_back(row);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** union_find_engine_unit: FAILED **");
         $finish;
      end
   end

   // result check first, then the request transaction of the same edge
   always @(posedge clock) begin : bus_monitor
      answer_type want;
      answer_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.root   = rsp_tdata[ufe_pkg::IDX_W-1:0];
            got.joined = rsp_tuser;
            if (root_answer_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: root %0d joined %0b", got.root, got.joined);
               mismatches++;
            end else begin
               want = root_answer_q.pop_front();
               if (want.root !== got.root || want.joined !== got.joined) begin
                  if (mismatches < 10)
                     $display("mismatch: expected root %0d joined %0b, got root %0d joined %0b",
                              want.root, want.joined, got.root, got.joined);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = resolve_item(req_tuser, req_tdata[ufe_pkg::IDX_W-1:0],
                                req_tdata[2*ufe_pkg::IDX_W-1:ufe_pkg::IDX_W]);
            if (cur_given) begin
               want.root   = cur_root;
               want.joined = cur_joined;
            end
            root_answer_q.push_back(want);
         end
      end
   end

   initial begin : rsp_sink
      int hold_cycles;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < HOLD_LEN) begin
               @(negedge clock);
               hold_cycles++;
            end
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   initial begin : req_source
      stim_row_type item;
      int           n;
      int           i;
      int           a;
      int           b;
      int           t;
      int           span;
      int           blk;
      int           base;
      int           win;

      for (i = 0; i < ufe_pkg::NODES; i++) begin
         node_is_root[i] = 1'b1;
         node_link[i]    = ufe_pkg::SIZE_W'(1);
      end

      for (i = 0; i < DIRECTED_ROWS; i++)
         stim_q.push_back(DIRECTED[i]);

      while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            // doubling build: equal-size merges give the deepest trees
            blk  = 1 << $urandom_range(2, 5);
            base = $urandom_range(0, ufe_pkg::NODES - blk);
            for (span = 1; span < blk; span = span * 2) begin
               for (i = 0; i < blk; i = i + 2 * span) begin
                  a = base + i + $urandom_range(0, span - 1);
                  b = base + i + span + $urandom_range(0, span - 1);
                  if ($urandom_range(0, 1) == 1) begin
                     t = a;
                     a = b;
                     b = t;
                  end
                  add_item(ufe_pkg::KIND_MERGE, a, b);
               end
            end
            repeat ($urandom_range(2, 6))
               add_item(ufe_pkg::KIND_FIND, base + $urandom_range(0, blk - 1),
                        $urandom_range(0, ufe_pkg::NODES - 1));
         end else begin
            win  = $urandom_range(16, 128);
            base = $urandom_range(0, ufe_pkg::NODES - win);
            repeat ($urandom_range(8, 24)) begin
               if ($urandom_range(0, 7) == 0)
                  add_item($urandom_range(0, 1) ? ufe_pkg::KIND_MERGE : ufe_pkg::KIND_FIND,
                           $urandom_range(0, ufe_pkg::NODES - 1),
                           $urandom_range(0, ufe_pkg::NODES - 1));
               else
                  add_item($urandom_range(0, 1) ? ufe_pkg::KIND_MERGE : ufe_pkg::KIND_FIND,
                           base + $urandom_range(0, win - 1), base + $urandom_range(0, win - 1));
            end
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the engine sweeps its table after reset; tready stays low until then
      for (n = 0; n < stim_q.size(); n++) begin
         item = stim_q[n];
         @(negedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= ufe_pkg::REQ_DATA_W'({item.node_b, item.node_a});
         req_tuser  <= item.kind;
         cur_given  <= item.given;
         cur_root   <= item.root;
         cur_joined <= item.joined;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (n == DIRECTED_ROWS + 40) hold_request = 1'b1;
         if (n >= stim_q.size() - CALM_TAIL) quiet = 1'b1;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (root_answer_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && root_answer_q.size() == 0) begin
         $display("** union_find_engine_unit: PASSED **");
      end else begin
         $display("** union_find_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule
